// ===== sv/bmli_pkg.sv =====
`timescale 1ns / 1ps
package bmli_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_CHR_ROM = 2'd0,
		KIND_NT_RAM  = 2'd1,
		KIND_PRG_ROM = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_INC   = 2'd1,
		MODE_RAM   = 2'd2,
		MODE_ALT   = 2'd3
	} mode_t;

	localparam logic CFG_QUIRK_MODE = 1'b0;
	localparam logic CFG_LINE_STEP  = 1'b1;

	localparam logic [14:0] CTR_MAX       = 15'h7FFF;
	localparam logic [14:0] LINE_STEP_RST = 15'd113;
	localparam logic [7:0]  CHR_ROM_LIMIT = 8'hE0;
	localparam logic [15:0] RAM_PORT_ADDR = 16'h4800;
	localparam logic [15:0] PTR_PORT_ADDR = 16'hF800;

	// 2K windows, address bits 15:11
	localparam logic [4:0] WIN_RAM_PORT = 5'd9;
	localparam logic [4:0] WIN_CTR_LO   = 5'd10;
	localparam logic [4:0] WIN_CTR_HI   = 5'd11;
	localparam logic [4:0] WIN_CHR_LAST = 5'd27;
	localparam logic [4:0] WIN_PRG0     = 5'd28;
	localparam logic [4:0] WIN_PRG1     = 5'd29;
	localparam logic [4:0] WIN_PRG2     = 5'd30;

	typedef struct packed {
		logic       we;
		logic [7:0] wptr;
		logic [7:0] wdata;
		logic [7:0] rptr;
	} ram_req_t;

endpackage

// ===== sv/bmli_ram.sv =====
`timescale 1ns / 1ps
module bmli_ram #(
	parameter int DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bmli_pkg::ram_req_t req,
	output logic [7:0]         rdata
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       mem_rd_q;
	logic [7:0]       byp_data_q;
	logic             byp_q;
	logic             vld_rd_q;
	logic [AW-1:0]    widx;
	logic [AW-1:0]    ridx;

	assign widx = req.wptr[AW-1:0];
	assign ridx = req.rptr[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[widx] <= req.wdata;
		end
		mem_rd_q   <= mem[ridx];
		byp_data_q <= req.wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			byp_q    <= 1'b0;
			vld_rd_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[widx] <= 1'b1;
			end
			byp_q    <= req.we && (widx == ridx);
			vld_rd_q <= vld_q[ridx];
		end
	end

	assign rdata = byp_q ? byp_data_q : (vld_rd_q ? mem_rd_q : 8'd0);

endmodule

// ===== sv/bank_mapper_with_line_irq_core.sv =====
`timescale 1ns / 1ps
// Cartridge bank mapper with a line-tick interrupt counter. One request is taken every
// cycle while req_stall is low; its result passes through the input register, then the
// result register. While a result waits under rsp_stall, one more request is taken into
// the input register, and then req_stall holds the input until the result is taken. The
// 128-byte internal RAM behind port 0x4800 is read ahead at the current pointer every
// cycle, so a RAM read finds its byte waiting. Per-entry valid bits make the RAM read
// as zero after reset with no clearing pass. Configuration writes are always ready.
module bank_mapper_with_line_irq_core #(
	parameter int RAM_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  op,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  read_data,
	output logic        irq_raise,
	output logic        map_valid,
	output logic [1:0]  map_kind,
	output logic [3:0]  map_slot,
	output logic [7:0]  map_page,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data
);

	logic                valid_s1;
	bmli_pkg::op_t       op_s1;
	logic [15:0]         address_s1;
	logic [7:0]          write_data_s1;

	bmli_pkg::mode_t     quirk_q;
	logic [14:0]         step_q;
	logic [14:0]         ctr_q;
	logic                en_q;
	logic                force_lo_q;
	logic                force_hi_q;
	logic [7:0]          ptr_q;

	logic [14:0]         ctr_d;
	logic                en_d;
	logic                force_lo_d;
	logic                force_hi_d;
	logic [7:0]          ptr_d;
	logic [7:0]          rd_d;
	logic                irq_d;
	logic                mv_d;
	bmli_pkg::kind_t     kind_d;
	logic [3:0]          slot_d;
	logic [7:0]          page_d;

	logic                adv;
	logic                fire;
	logic                mode2;
	logic                ram_acc;
	logic [4:0]          win;
	logic [14:0]         hi_load;
	logic                rom;
	logic [1:0]          prg_slot;
	logic [7:0]          ram_byte;
	bmli_pkg::ram_req_t  ram_req;

	assign adv       = !rsp_valid || !rsp_stall;
	assign fire      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	assign mode2   = (quirk_q == bmli_pkg::MODE_RAM);
	assign win     = address_s1[15:11];
	assign ram_acc = mode2 && (address_s1 == bmli_pkg::RAM_PORT_ADDR) &&
		((op_s1 == bmli_pkg::OP_READ) || (op_s1 == bmli_pkg::OP_WRITE));
	assign hi_load  = {write_data_s1[6:0], ctr_q[7:0]};
	assign prg_slot = 2'(win - bmli_pkg::WIN_PRG0);

	always_comb begin
		ctr_d      = ctr_q;
		en_d       = en_q;
		force_lo_d = force_lo_q;
		force_hi_d = force_hi_q;
		ptr_d      = ptr_q;
		rd_d       = 8'd0;
		irq_d      = 1'b0;
		mv_d       = 1'b0;
		kind_d     = bmli_pkg::KIND_CHR_ROM;
		slot_d     = 4'd0;
		page_d     = 8'd0;
		rom        = 1'b1;
		if (ram_acc && ptr_q[7]) begin
			ptr_d = {1'b1, 7'(ptr_q[6:0] + 7'd1)};
		end
		unique case (op_s1)
			bmli_pkg::OP_READ: begin
				if (address_s1 == bmli_pkg::RAM_PORT_ADDR) begin
					rd_d = mode2 ? ram_byte : 8'd0;
				end else if (win == bmli_pkg::WIN_CTR_LO) begin
					rd_d = ctr_q[7:0];
				end else if (win == bmli_pkg::WIN_CTR_HI) begin
					rd_d = {1'b0, ctr_q[14:8]};
				end else begin
					rd_d = address_s1[15:8];
				end
			end
			bmli_pkg::OP_WRITE: begin
				if (win == bmli_pkg::WIN_CTR_LO) begin
					ctr_d = {ctr_q[14:8], write_data_s1};
				end else if (win == bmli_pkg::WIN_CTR_HI) begin
					en_d = write_data_s1[7];
					if ((quirk_q != bmli_pkg::MODE_PLAIN) && (hi_load != bmli_pkg::CTR_MAX)) begin
						ctr_d = 15'(hi_load + 15'd1);
					end else begin
						ctr_d = hi_load;
					end
				end else if (address_s1[15] && (win <= bmli_pkg::WIN_CHR_LAST)) begin
					if (address_s1[14:13] == 2'd0) begin
						rom = (write_data_s1 < bmli_pkg::CHR_ROM_LIMIT) || force_lo_q;
					end else if (address_s1[14:13] == 2'd1) begin
						rom = (write_data_s1 < bmli_pkg::CHR_ROM_LIMIT) || force_hi_q;
					end else begin
						rom = (write_data_s1 < bmli_pkg::CHR_ROM_LIMIT);
					end
					mv_d   = 1'b1;
					slot_d = address_s1[14:11];
					kind_d = rom ? bmli_pkg::KIND_CHR_ROM : bmli_pkg::KIND_NT_RAM;
					page_d = rom ? write_data_s1 : {7'd0, write_data_s1[0]};
				end else if ((win == bmli_pkg::WIN_PRG0) || (win == bmli_pkg::WIN_PRG1) ||
						(win == bmli_pkg::WIN_PRG2)) begin
					mv_d   = 1'b1;
					kind_d = bmli_pkg::KIND_PRG_ROM;
					slot_d = {2'd0, prg_slot};
					page_d = {2'd0, write_data_s1[5:0]};
					if (win == bmli_pkg::WIN_PRG1) begin
						force_lo_d = write_data_s1[6];
						force_hi_d = write_data_s1[7];
					end
				end else if (mode2 && (address_s1 == bmli_pkg::PTR_PORT_ADDR)) begin
					ptr_d = write_data_s1;
				end
			end
			bmli_pkg::OP_TICK: begin
				if (en_q) begin
					if (ctr_q >= 15'(bmli_pkg::CTR_MAX - step_q)) begin
						ctr_d = bmli_pkg::CTR_MAX;
						irq_d = 1'b1;
					end else begin
						ctr_d = 15'(ctr_q + step_q);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_req.we    = fire && ram_acc && (op_s1 == bmli_pkg::OP_WRITE);
		ram_req.wptr  = ptr_q;
		ram_req.wdata = write_data_s1;
		ram_req.rptr  = fire ? ptr_d : ptr_q;
	end

	bmli_ram #(
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ram_req),
		.rdata (ram_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			rsp_valid  <= 1'b0;
			quirk_q    <= bmli_pkg::MODE_PLAIN;
			step_q     <= bmli_pkg::LINE_STEP_RST;
			ctr_q      <= '0;
			en_q       <= 1'b0;
			force_lo_q <= 1'b0;
			force_hi_q <= 1'b0;
			ptr_q      <= '0;
		end else begin
			if (!valid_s1 || adv) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid <= valid_s1;
			end
			if (fire) begin
				ctr_q      <= ctr_d;
				en_q       <= en_d;
				force_lo_q <= force_lo_d;
				force_hi_q <= force_hi_d;
				ptr_q      <= ptr_d;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bmli_pkg::CFG_QUIRK_MODE) begin
					quirk_q <= bmli_pkg::mode_t'(cfg_data[1:0]);
				end else begin
					step_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!valid_s1 || adv) begin
			op_s1         <= bmli_pkg::op_t'(op);
			address_s1    <= address;
			write_data_s1 <= write_data;
		end
		if (fire) begin
			read_data <= rd_d;
			irq_raise <= irq_d;
			map_valid <= mv_d;
			map_kind  <= kind_d;
			map_slot  <= slot_d;
			map_page  <= page_d;
		end
	end

endmodule

// ===== tb/tb_bank_mapper_with_line_irq_core.sv =====
`timescale 1ns / 1ps
module tb_bank_mapper_with_line_irq_core;
	import bmli_pkg::*;

	typedef struct packed {
		logic [7:0] rd;
		logic       irq;
		logic       mv;
		kind_t      kind;
		logic [3:0] slot;
		logic [7:0] page;
	} rsp_t;

	typedef struct {
		mode_t       mode;
		op_t         op;
		logic [15:0] addr;
		logic [7:0]  data;
		bit          known;
		rsp_t        want;
	} plan_t;

	localparam rsp_t NIL = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	op_t         op;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [7:0]  read_data;
	logic        irq_raise;
	logic        map_valid;
	logic [1:0]  map_kind;
	logic [3:0]  map_slot;
	logic [7:0]  map_page;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [14:0] cfg_data;

	bank_mapper_with_line_irq_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.address    (address),
		.write_data (write_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_data  (read_data),
		.irq_raise  (irq_raise),
		.map_valid  (map_valid),
		.map_kind   (map_kind),
		.map_slot   (map_slot),
		.map_page   (map_page),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// mapper state as the testbench sees it
	mode_t       cur_mode;
	logic [14:0] cur_step;
	logic [14:0] ctr;
	logic        ctr_en;
	logic        force_lo;
	logic        force_hi;
	logic [7:0]  ptr;
	logic [7:0]  ram_img [128];

	rsp_t  awaited_rsp [$];
	plan_t plan [$];
	int    sent;
	int    rsp_seen;
	int    irq_seen;
	int    map_seen;
	int    faults;
	bit    tx_idle;
	bit    rx_idle;
	bit    rush;
	bit    squeeze;

	function automatic void advance_ptr();
		if (ptr[7])
			ptr = {1'b1, ptr[6:0] + 7'd1};
	endfunction

	function automatic rsp_t bus_outcome(op_t o, logic [15:0] a, logic [7:0] d);
		rsp_t       r;
		logic [4:0] win;
		logic       rom;
		r = '0;
		win = a[15:11];
		case (o)
			OP_READ: begin
				if (a == RAM_PORT_ADDR) begin
					if (cur_mode == MODE_RAM) begin
						r.rd = ram_img[ptr[6:0]];
						advance_ptr();
					end
				end else if (win == WIN_CTR_LO) begin
					r.rd = ctr[7:0];
				end else if (win == WIN_CTR_HI) begin
					r.rd = {1'b0, ctr[14:8]};
				end else begin
					r.rd = a[15:8];
				end
			end
			OP_WRITE: begin
				if (win == WIN_RAM_PORT) begin
					if (a == RAM_PORT_ADDR && cur_mode == MODE_RAM) begin
						ram_img[ptr[6:0]] = d;
						advance_ptr();
					end
				end else if (win == WIN_CTR_LO) begin
					ctr[7:0] = d;
				end else if (win == WIN_CTR_HI) begin
					ctr[14:8] = d[6:0];
					ctr_en = d[7];
					if (cur_mode != MODE_PLAIN && ctr != CTR_MAX)
						ctr = ctr + 15'd1;
				end else if (a[15] && win <= WIN_CHR_LAST) begin
					r.mv = 1'b1;
					r.slot = a[14:11];
					if (r.slot < 4'd4)
						rom = d < CHR_ROM_LIMIT || force_lo;
					else if (r.slot < 4'd8)
						rom = d < CHR_ROM_LIMIT || force_hi;
					else
						rom = d < CHR_ROM_LIMIT;
					if (rom) begin
						r.kind = KIND_CHR_ROM;
						r.page = d;
					end else begin
						r.kind = KIND_NT_RAM;
						r.page = {7'd0, d[0]};
					end
				end else if (win == WIN_PRG0 || win == WIN_PRG1 || win == WIN_PRG2) begin
					r.mv = 1'b1;
					r.kind = KIND_PRG_ROM;
					r.slot = {2'b00, a[12:11]};
					r.page = {2'b00, d[5:0]};
					if (win == WIN_PRG1) begin
						force_lo = d[6];
						force_hi = d[7];
					end
				end else if (a == PTR_PORT_ADDR && cur_mode == MODE_RAM) begin
					ptr = d;
				end
			end
			OP_TICK: begin
				if (ctr_en) begin
					if (ctr >= CTR_MAX - cur_step) begin
						ctr = CTR_MAX;
						r.irq = 1'b1;
					end else begin
						ctr = ctr + cur_step;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void row(mode_t m, op_t o, logic [15:0] a, logic [7:0] d, bit known,
			rsp_t want);
		plan_t p;
		p.mode = m;
		p.op = o;
		p.addr = a;
		p.data = d;
		p.known = known;
		p.want = want;
		plan.push_back(p);
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(8'hDC, 8'hE3));
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] pick_addr();
		logic [15:0] a;
		a = 16'($urandom);
		case ($urandom_range(0, 7))
			1: a = RAM_PORT_ADDR;
			2: a = PTR_PORT_ADDR;
			3: a[15:12] = 4'h5;
			4: a = 16'($urandom_range(16'h8000, 16'hDFFF));
			5: a = 16'($urandom_range(16'hE000, 16'hF7FF));
			6: a = 16'($urandom_range(16'h4801, 16'h4FFF));
			7: a = 16'($urandom_range(16'hF801, 16'hFFFF));
			default: ;
		endcase
		return a;
	endfunction

	task automatic push(op_t o, logic [15:0] a, logic [7:0] d, bit known = 1'b0,
			rsp_t want = '0);
		int   gap;
		rsp_t p;
		if (!rush && $urandom_range(0, 19) == 0)
			tx_idle = !tx_idle;
		gap = (tx_idle && !rush) ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		op <= o;
		address <= a;
		write_data <= d;
		do @(posedge clk); while (req_stall);
		p = bus_outcome(o, a, d);
		awaited_rsp.push_back(known ? want : p);
		sent++;
		@(negedge clk);
	endtask

	// drop valid and let the pipe empty before touching registers
	task automatic settle();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(mode_t m, logic [14:0] s);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_QUIRK_MODE;
		cfg_data <= {13'd0, m};
		do @(posedge clk); while (!cfg_ready);
		cur_mode = m;
		@(negedge clk);
		cfg_index <= CFG_LINE_STEP;
		cfg_data <= s;
		do @(posedge clk); while (!cfg_ready);
		cur_step = s;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_burst();
		int          n;
		logic [15:0] a;
		logic [7:0]  d;
		logic [7:0]  base;
		case ($urandom_range(0, 9))
			0, 1: begin
				a = 16'($urandom);
				a[15:11] = WIN_CTR_LO;
				push(OP_WRITE, a, pick_byte());
				a = 16'($urandom);
				a[15:11] = WIN_CTR_HI;
				d = 8'($urandom);
				d[7] = ($urandom_range(0, 9) != 0);
				push(OP_WRITE, a, d);
				n = $urandom_range(1, 12);
				repeat (n) push(OP_TICK, 16'($urandom), 8'($urandom));
				a[15:11] = WIN_CTR_LO;
				push(OP_READ, a, 8'($urandom));
				a[15:11] = WIN_CTR_HI;
				push(OP_READ, a, 8'($urandom));
			end
			2, 3: begin
				base = 8'($urandom);
				base[7] = ($urandom_range(0, 4) != 0);
				push(OP_WRITE, PTR_PORT_ADDR, base);
				n = $urandom_range(1, 8);
				repeat (n) push(OP_WRITE, RAM_PORT_ADDR, 8'($urandom));
				push(OP_WRITE, PTR_PORT_ADDR, base);
				repeat (n) push(OP_READ, RAM_PORT_ADDR, 8'($urandom));
			end
			4, 5, 6: begin
				n = $urandom_range(1, 6);
				repeat (n) push(OP_WRITE, 16'($urandom_range(16'h8000, 16'hF7FF)), pick_byte());
			end
			default: push(op_t'($urandom_range(0, 3)), pick_addr(), pick_byte());
		endcase
	endtask

	always @(posedge clk) begin
		rsp_t got;
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = {read_data, irq_raise, map_valid, map_kind, map_slot, map_page};
			rsp_seen++;
			if (got.irq)
				irq_seen++;
			if (got.mv)
				map_seen++;
			if (awaited_rsp.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected response rd=%h irq=%b mv=%b kind=%0d slot=%0d page=%h",
						got.rd, got.irq, got.mv, got.kind, got.slot, got.page);
			end else begin
				exp_rsp = awaited_rsp.pop_front();
				if (got !== exp_rsp) begin
					faults++;
					if (faults <= 10)
						$display({"response %0d mismatch: exp rd=%h irq=%b mv=%b kind=%0d ",
							"slot=%0d page=%h, got rd=%h irq=%b mv=%b kind=%0d slot=%0d page=%h"},
							rsp_seen, exp_rsp.rd, exp_rsp.irq, exp_rsp.mv, exp_rsp.kind,
							exp_rsp.slot, exp_rsp.page, got.rd, got.irq, got.mv, got.kind,
							got.slot, got.page);
				end
			end
		end
	end

	initial begin : drain_side
		int w;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (squeeze) begin
				w = 150;
				squeeze = 1'b0;
			end else begin
				if ($urandom_range(0, 19) == 0)
					rx_idle = !rx_idle;
				w = rx_idle ? $urandom_range(0, 16) : 0;
			end
			if (w > 0) begin
				rsp_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("tb_bank_mapper_with_line_irq_core: errors");
		$finish;
	end

	initial begin
		int guard;
		req_valid = 1'b0;
		op = OP_READ;
		address = '0;
		write_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_QUIRK_MODE;
		cfg_data = '0;
		arst_n = 1'b0;
		cur_mode = MODE_PLAIN;
		cur_step = LINE_STEP_RST;
		ctr = '0;
		ctr_en = 1'b0;
		force_lo = 1'b0;
		force_hi = 1'b0;
		ptr = '0;
		foreach (ram_img[i])
			ram_img[i] = '0;
		sent = 0;
		rsp_seen = 0;
		irq_seen = 0;
		map_seen = 0;
		faults = 0;
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		rush = 1'b0;
		squeeze = 1'b0;

		row(MODE_PLAIN, OP_READ,  16'h5000, 8'h00, 1, {8'h00, 1'b0, 1'b0, KIND_CHR_ROM, 4'd0, 8'h00});
		row(MODE_PLAIN, OP_READ,  16'hFFFF, 8'h00, 1, {8'hFF, 1'b0, 1'b0, KIND_CHR_ROM, 4'd0, 8'h00});
		row(MODE_PLAIN, OP_READ,  16'h4800, 8'h00, 1, NIL);
		row(MODE_PLAIN, OP_WRITE, 16'h8000, 8'h00, 1, {8'h00, 1'b0, 1'b1, KIND_CHR_ROM, 4'd0, 8'h00});
		row(MODE_PLAIN, OP_WRITE, 16'hDFFF, 8'hFF, 1, {8'h00, 1'b0, 1'b1, KIND_NT_RAM, 4'd11, 8'h01});
		row(MODE_PLAIN, OP_WRITE, 16'h9000, 8'hDF, 1, {8'h00, 1'b0, 1'b1, KIND_CHR_ROM, 4'd2, 8'hDF});
		row(MODE_PLAIN, OP_WRITE, 16'hE800, 8'hC1, 1, {8'h00, 1'b0, 1'b1, KIND_PRG_ROM, 4'd1, 8'h01});
		row(MODE_PLAIN, OP_WRITE, 16'h8800, 8'hE1, 0, NIL);
		row(MODE_PLAIN, OP_WRITE, 16'hA000, 8'hFE, 0, NIL);
		row(MODE_PLAIN, OP_WRITE, 16'hC000, 8'hE3, 0, NIL);
		row(MODE_PLAIN, OP_WRITE, 16'hF000, 8'hFF, 1, {8'h00, 1'b0, 1'b1, KIND_PRG_ROM, 4'd2, 8'h3F});
		row(MODE_PLAIN, OP_WRITE, 16'h5000, 8'hF0, 1, NIL);
		row(MODE_PLAIN, OP_WRITE, 16'h5800, 8'hFF, 1, NIL);
		row(MODE_PLAIN, OP_TICK,  16'h0000, 8'h00, 1, {8'h00, 1'b1, 1'b0, KIND_CHR_ROM, 4'd0, 8'h00});
		row(MODE_PLAIN, OP_READ,  16'h5800, 8'h00, 1, {8'h7F, 1'b0, 1'b0, KIND_CHR_ROM, 4'd0, 8'h00});
		row(MODE_PLAIN, OP_WRITE, 16'h5800, 8'h00, 1, NIL);
		row(MODE_PLAIN, OP_TICK,  16'hFFFF, 8'hFF, 1, NIL);
		row(MODE_PLAIN, OP_NONE,  16'hFFFF, 8'hFF, 1, NIL);
		row(MODE_PLAIN, OP_WRITE, 16'hF800, 8'h80, 1, NIL);
		row(MODE_RAM,   OP_WRITE, 16'hF800, 8'hFF, 1, NIL);
		row(MODE_RAM,   OP_WRITE, 16'h4800, 8'hA5, 1, NIL);
		row(MODE_RAM,   OP_WRITE, 16'h4800, 8'h5A, 1, NIL);
		row(MODE_RAM,   OP_WRITE, 16'hF800, 8'hFF, 1, NIL);
		row(MODE_RAM,   OP_READ,  16'h4800, 8'h00, 0, NIL);
		row(MODE_RAM,   OP_READ,  16'h4800, 8'h00, 0, NIL);
		row(MODE_RAM,   OP_WRITE, 16'h5800, 8'hFE, 0, NIL);
		row(MODE_RAM,   OP_READ,  16'h5000, 8'h00, 0, NIL);
		row(MODE_RAM,   OP_READ,  16'h4801, 8'h00, 1, {8'h48, 1'b0, 1'b0, KIND_CHR_ROM, 4'd0, 8'h00});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].mode != cur_mode) begin
				settle();
				set_config(plan[i].mode, cur_step);
			end
			push(plan[i].op, plan[i].addr, plan[i].data, plan[i].known, plan[i].want);
		end

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
				0: set_config(MODE_INC, 15'd0);
				1: set_config(MODE_RAM, CTR_MAX);
				2: set_config(MODE_PLAIN, LINE_STEP_RST);
				3: set_config(MODE_ALT, 15'd1);
				4: set_config(MODE_RAM, 15'($urandom_range(1, 2000)));
				5: set_config(MODE_INC, 15'($urandom));
				6: set_config(MODE_PLAIN, CTR_MAX);
				default: set_config(MODE_RAM, LINE_STEP_RST);
			endcase
			// hold the response side off while requests keep coming
			rush = (ph == 2);
			squeeze = (ph == 2);
			guard = sent + 155;
			while (sent < guard)
				random_burst();
		end
		rush = 1'b0;

		req_valid <= 1'b0;
		guard = 0;
		while (awaited_rsp.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
		if (awaited_rsp.size() != 0) begin
			faults += awaited_rsp.size();
			$display("%0d responses never arrived", awaited_rsp.size());
		end
		$display("%0d requests sent over modes 0-3 and line steps 0..7FFF, %0d responses checked",
			sent, rsp_seen);
		$display("%0d interrupt raises, %0d bank remaps, %0d failures", irq_seen, map_seen, faults);
		if (faults == 0)
			$display("tb_bank_mapper_with_line_irq_core: clean");
		else
			$display("tb_bank_mapper_with_line_irq_core: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/bmli_pkg.sv
sv/bmli_ram.sv
sv/bank_mapper_with_line_irq_core.sv
tb/tb_bank_mapper_with_line_irq_core.sv
